>>> rtl/pus2_pkg.sv
// Shared types, constants and the coefficient table for the 2x polyphase upsampler.
// Used by pus2_ctrl, pus2_dp and polyphase_upsample_by_two_unit; depends on nothing.
package pus2_pkg;

  localparam int FILTER_TAPS = 40;
  localparam int HALF        = FILTER_TAPS / 2;
  localparam int SAMPLE_BITS = 8;
  localparam int LINE_BITS   = 12;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W       = PROD_W + 1;
  localparam int FRAC        = 16;

  localparam int J_W   = $clog2(HALF);
  localparam int D_W   = $clog2(HALF - 1);
  localparam int K_W   = J_W + 1;
  localparam int POS_W = $clog2(HALF);
  localparam int Q_W   = J_W + 1;

  // Output offset within one step: last output of a regular step and of a flush.
  localparam int D_LAST_RUN   = 1;
  localparam int D_LAST_FLUSH = HALF - 2;
  // First output of a step sits at 2n - D_LEAD; negative positions are dropped.
  localparam int D_LEAD       = HALF - 3;

  typedef struct packed {
    logic           accept;
    logic           issue;
    logic           clear;
    logic           load;
    logic           last;
    logic           done;
    logic [D_W-1:0] d;
    logic [J_W-1:0] j;
  } dp_cmd_t;

  typedef struct packed {
    logic [D_W-1:0] d_first;
    logic           no_out;
    logic           line_end;
    logic           out_free;
  } dp_sts_t;

  // Q.16 coefficients with the factor two folded in.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [K_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      6'd0:  c = -18'sd39;
      6'd1:  c = -18'sd128;
      6'd2:  c = 18'sd235;
      6'd3:  c = 18'sd360;
      6'd4:  c = -18'sd508;
      6'd5:  c = -18'sd679;
      6'd6:  c = 18'sd879;
      6'd7:  c = 18'sd1110;
      6'd8:  c = -18'sd1381;
      6'd9:  c = -18'sd1698;
      6'd10: c = 18'sd2074;
      6'd11: c = 18'sd2527;
      6'd12: c = -18'sd3084;
      6'd13: c = -18'sd3790;
      6'd14: c = 18'sd4721;
      6'd15: c = 18'sd6023;
      6'd16: c = -18'sd8010;
      6'd17: c = -18'sd11499;
      6'd18: c = 18'sd19485;
      6'd19: c = 18'sd58938;
      6'd20: c = 18'sd58938;
      6'd21: c = 18'sd19485;
      6'd22: c = -18'sd11499;
      6'd23: c = -18'sd8010;
      6'd24: c = 18'sd6023;
      6'd25: c = 18'sd4721;
      6'd26: c = -18'sd3790;
      6'd27: c = -18'sd3084;
      6'd28: c = 18'sd2527;
      6'd29: c = 18'sd2074;
      6'd30: c = -18'sd1698;
      6'd31: c = -18'sd1381;
      6'd32: c = 18'sd1110;
      6'd33: c = 18'sd879;
      6'd34: c = -18'sd679;
      6'd35: c = -18'sd508;
      6'd36: c = 18'sd360;
      6'd37: c = 18'sd235;
      6'd38: c = -18'sd128;
      6'd39: c = -18'sd39;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/polyphase_upsample_by_two_unit.sv
// Top level of the 2x polyphase line upsampler: controller plus datapath.
// Depends on pus2_pkg, pus2_ctrl and pus2_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready): one 8-bit sample of a line per item;
//    in_line_end marks the last sample and flushes the rest of the line.
//  - Output channel (out_valid/out_ready): interpolated samples, two per input
//    from the tenth sample of a line on, one for the ninth; out_run_last flags
//    the last result of an input item, out_line_done the final output of the line.
//  - Each output is a 20-tap MAC on one shared multiplier: one tap per cycle,
//    then a drain step for the product register, then a load step that rounds
//    into the output register. An input item takes an accept and a start step,
//    then these steps for each of its outputs: none for the first eight samples
//    of a line, up to two for a regular item, up to 19 for a flush.
//  - The output register decouples the sides: the next input is taken while
//    the last result of the previous one still waits. A stalled receiver
//    holds the sequencer in its load step; nothing is dropped.
//  - Reset clears the line position and both valid flags; the sample window
//    needs no clearing since slots before the line start read the first sample.
module polyphase_upsample_by_two_unit import pus2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_line_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic                   out_run_last,
  output logic                   out_line_done
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence outputs of an item and taps of an output.
  pus2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the window, run the MAC, hold the result until taken.
  pus2_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_sample),
    .in_line_end   (in_line_end),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_sample    (out_sample),
    .out_run_last  (out_run_last),
    .out_line_done (out_line_done)
  );

  // A result is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending output");

  // No tap is issued while the block can take a new item.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.issue && !cmd.load)
    else $error("datapath busy while input is open");

  // The final output of a line closes the run of its item.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_run_last)
    else $error("line_done without run_last");

  // A loaded result is presented in the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

endmodule

>>> rtl/pus2_ctrl.sv
// Sequencer for the 2x upsampler: walks outputs and taps, drives the datapath.
// Depends on pus2_pkg.
module pus2_ctrl import pus2_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TAP   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [D_W-1:0] d_r, d_nxt;
  logic [J_W-1:0] j_r, j_nxt;
  logic [D_W-1:0] d_last;

  assign d_last   = sts.line_end ? D_W'(D_LAST_FLUSH) : D_W'(D_LAST_RUN);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    j_nxt      = j_r;
    cmd        = '0;
    cmd.d      = d_r;
    cmd.j      = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        if (sts.no_out) begin
          state_nxt = S_IDLE;
        end else begin
          d_nxt     = sts.d_first;
          j_nxt     = '0;
          state_nxt = S_TAP;
        end
      end
      S_TAP: begin
        cmd.issue = 1'b1;
        cmd.clear = (j_r == '0);
        if (j_r == J_W'(HALF - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.last = (d_r == d_last);
          cmd.done = (d_r == d_last) && sts.line_end;
          if (d_r == d_last) begin
            state_nxt = S_IDLE;
          end else begin
            d_nxt     = d_r + 1'b1;
            j_nxt     = '0;
            state_nxt = S_TAP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      d_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

>>> rtl/pus2_dp.sv
// Datapath of the 2x upsampler: sample window, tap select, MAC, round/saturate, output register.
// Depends on pus2_pkg.
module pus2_dp import pus2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_line_end,
  input  logic                   out_ready,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic                   out_run_last,
  output logic                   out_line_done
);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC - 1);

  logic [SAMPLE_BITS-1:0]   win_r [HALF];
  logic [SAMPLE_BITS-1:0]   first_r;
  logic [LINE_BITS-1:0]     count_r;
  logic [LINE_BITS-1:0]     n_r;
  logic                     end_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r;
  logic [SAMPLE_BITS-1:0]   out_sample_r;
  logic                     out_run_last_r;
  logic                     out_line_done_r;

  logic [Q_W-1:0]           q;
  logic [POS_W-1:0]         pos;
  logic                     use_first;
  logic [SAMPLE_BITS-1:0]   tap_sample;
  logic [K_W-1:0]           k;
  logic signed [PROD_W-1:0] coef_ext, smp_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic [SAMPLE_BITS-1:0]   res;
  logic [LINE_BITS:0]       n2;
  logic [LINE_BITS:0]       lead;

  // Tap j of output offset d reads window slot (d/2)+j, clamped at the newest entry;
  // slots before line start read the first sample.
  assign q          = Q_W'(cmd.d >> 1) + Q_W'(cmd.j);
  assign pos        = (q > Q_W'(HALF - 1)) ? POS_W'(HALF - 1) : q[POS_W-1:0];
  assign use_first  = ({1'b0, n_r} + (LINE_BITS + 1)'(q)) < (LINE_BITS + 1)'(HALF - 1);
  assign tap_sample = use_first ? first_r : win_r[pos];
  assign k          = {cmd.j, ~cmd.d[0]};
  assign coef_ext   = PROD_W'(coef_at(k));
  assign smp_ext    = PROD_W'($signed({1'b0, tap_sample}));
  assign prod_nxt   = coef_ext * smp_ext;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // Clamp negative to zero, round half up, clamp to full scale.
  assign rnd = acc_r + RND_HALF;
  always_comb begin
    priority if (acc_r < 0) begin
      res = '0;
    end else if (|rnd[ACC_W-1:FRAC+SAMPLE_BITS]) begin
      res = '1;
    end else begin
      res = rnd[FRAC+SAMPLE_BITS-1:FRAC];
    end
  end

  // First output offset of this step; earlier ones fall before the line start.
  assign n2   = {n_r, 1'b0};
  assign lead = (LINE_BITS + 1)'(D_LEAD) - n2;
  always_comb begin
    sts          = '0;
    sts.d_first  = (n2 >= (LINE_BITS + 1)'(D_LEAD)) ? '0 : lead[D_W-1:0];
    sts.no_out   = !end_r && (sts.d_first > D_W'(D_LAST_RUN));
    sts.line_end = end_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < HALF - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[HALF-1] <= in_sample;
      if (count_r == '0) begin
        first_r <= in_sample;
      end
      n_r   <= count_r;
      end_r <= in_line_end;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load) begin
      out_sample_r    <= res;
      out_run_last_r  <= cmd.last;
      out_line_done_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_v_r <= cmd.issue;
      if (cmd.accept) begin
        count_r <= in_line_end ? '0 : count_r + 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_run_last  = out_run_last_r;
  assign out_line_done = out_line_done_r;

endmodule

>>> sim/tb.sv
// Self-checking bench for polyphase_upsample_by_two_unit: a 2x line interpolator
// with in_/out_ valid-ready channels. It carries its own fixed-point model of the filter.
// Depends on rtl/pus2_pkg.sv and the RTL under rtl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pus2_pkg::*;

  // Give up after this many cycles in which neither channel moves an item.
  localparam int STALL_LIMIT = 4000;
  // Length of the receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 800;
  localparam int REPORT_MAX  = 10;
  localparam int ROUND_HALF  = 1 << (FRAC - 1);
  localparam int PX_MAX      = (1 << SAMPLE_BITS) - 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] px;
    logic                   run_last;
    logic                   line_done;
  } px_result_t;

  typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_SMOOTH} fill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic in_line_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic out_run_last;
  logic out_line_done;

  // Q.16 taps of the symmetric 40-tap half-band-like kernel, factor two folded in.
  int tap_q16 [FILTER_TAPS] = '{
    -39, -128, 235, 360, -508, -679, 879, 1110, -1381, -1698,
    2074, 2527, -3084, -3790, 4721, 6023, -8010, -11499, 19485, 58938,
    58938, 19485, -11499, -8010, 6023, 4721, -3790, -3084, 2527, 2074,
    -1698, -1381, 1110, 879, -679, -508, 360, 235, -128, -39
  };

  // Model state: sliding window (last entry newest), position in line, line head.
  logic [SAMPLE_BITS-1:0] line_window [HALF];
  logic [11:0]            line_pos;
  logic [SAMPLE_BITS-1:0] line_head;

  px_result_t expected_px [$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int items_sent    = 0;
  int lines_sent    = 0;
  int px_checked    = 0;
  int fail_count    = 0;

  polyphase_upsample_by_two_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_line_end   (in_line_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_run_last  (out_run_last),
    .out_line_done (out_line_done)
  );

  always #6ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------

  // Fetch line sample idx; newest index is n, window entry 0 holds index b.
  // Clamp left of the line to its first sample and right of it to the newest one.
  function automatic int tap_sample(input int idx, input int n, input int b);
    int pos;
    if (idx < 0) begin
      return int'(line_head);
    end
    if (idx > n) idx = n;
    pos = idx - b;
    if (pos < 0) pos = 0;
    if (pos > HALF - 1) pos = HALF - 1;
    return int'(line_window[pos]);
  endfunction

  // One output: 20 taps of one phase, clip negatives, round half up, clip at full scale.
  function automatic logic [SAMPLE_BITS-1:0] interp_point(input int base, input int phase,
                                                          input int n, input int b);
    longint acc;
    longint rounded;
    int j;
    acc = 0;
    for (j = 0; j < HALF; j++) begin
      acc += longint'(tap_q16[phase + 2 * j]) * longint'(tap_sample(base + j, n, b));
    end
    if (acc < 0) return '0;
    rounded = (acc + ROUND_HALF) >>> FRAC;
    if (rounded > PX_MAX) return PX_MAX[SAMPLE_BITS-1:0];
    return rounded[SAMPLE_BITS-1:0];
  endfunction

  // Advance the model by one accepted sample and queue every output it completes.
  function automatic void interp_predict(input logic [SAMPLE_BITS-1:0] s, input logic e);
    int n, b, x0, last_d, d, i;
    px_result_t r;
    px_result_t step_q [$];
    n = int'(line_pos);
    b = n - HALF + 1;
    x0 = 2 * b + HALF + 1;
    last_d = e ? (2 * n + 1 - x0) : 1;
    if (n == 0) line_head = s;
    for (i = 0; i < HALF - 1; i++) line_window[i] = line_window[i + 1];
    line_window[HALF - 1] = s;
    for (d = 0; d <= last_d; d++) begin
      if (x0 + d >= 0) begin
        r.px        = interp_point(b + (d >> 1), 1 - (d & 1), n, b);
        r.run_last  = 1'b0;
        r.line_done = 1'b0;
        step_q.push_back(r);
      end
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_last  = 1'b1;
      step_q[step_q.size() - 1].line_done = e;
    end
    foreach (step_q[i]) expected_px.push_back(step_q[i]);
    line_pos = e ? 12'd0 : line_pos + 12'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted output with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected output: sample %0d run_last %0b line_done %0b",
                   out_sample, out_run_last, out_line_done);
      end else begin
        px_checked++;
        if (expected_px[0] !== {out_sample, out_run_last, out_line_done}) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"mismatch on output %0d: expected sample %0d run_last %0b ",
                      "line_done %0b, got sample %0d run_last %0b line_done %0b"},
                     px_checked, expected_px[0].px, expected_px[0].run_last,
                     expected_px[0].line_done, out_sample, out_run_last, out_line_done);
        end
        void'(expected_px.pop_front());
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d outputs still expected",
               STALL_LIMIT, expected_px.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one sample; enter and leave at a falling edge, with valid left high
  // so that a back-to-back item keeps it up without a glitch.
  task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sample   <= s;
    in_line_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    interp_predict(s, e);
    items_sent++;
    if (e) lines_sent++;
    @(negedge clk);
  endtask

  // Send a whole line of len samples, the last one flagged as line end.
  task automatic send_line(input int len, input fill_t fill);
    int i;
    int level;
    logic [SAMPLE_BITS-1:0] s;
    level = $urandom_range(PX_MAX);
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_EXTREME: begin
          s = $urandom_range(1) ? PX_MAX[SAMPLE_BITS-1:0] : '0;
        end
        FILL_SMOOTH: begin
          level = level + $urandom_range(16) - 8;
          if (level < 0) level = 0;
          if (level > PX_MAX) level = PX_MAX;
          s = level[SAMPLE_BITS-1:0];
        end
        default: begin
          s = SAMPLE_BITS'($urandom_range(PX_MAX));
        end
      endcase
      send_item(s, i == len - 1);
    end
  endtask

  // Drop valid, wait out every expected output, then let the pipe settle.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short lines that only flush, full-scale steps that drive both clips.
  task automatic test_directed_edges();
    int i;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // one-sample line: the flush alone makes both outputs
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // eight samples: nothing comes out before the flush
    for (i = 0; i < 8; i++) send_item(i[0] ? 8'hFF : 8'h00, i == 7);
    // twelve samples: steady outputs start at the ninth, steps overshoot both rails
    for (i = 0; i < 12; i++) send_item((i % 3 == 0) ? 8'h00 : 8'hFF, i == 11);
    drain_outputs();
  endtask

  // Random lines under four idle mixes; mostly lines long enough for steady output.
  task automatic test_random_lines();
    int ph, phase_start, len;
    fill_t fill;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
        default: begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 18) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 28);
        case ($urandom_range(3))
          0: fill = FILL_EXTREME;
          1: fill = FILL_SMOOTH;
          default: fill = FILL_UNIFORM;
        endcase
        send_line(len, fill);
      end
      drain_outputs();
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up.
  task automatic test_receiver_holdoff();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = HOLD_CYCLES;
    send_line(30, FILL_UNIFORM);
    drain_outputs();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (line_window[i]) line_window[i] = '0;
    line_pos  = '0;
    line_head = '0;
    // hold reset, release at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_random_lines();
    test_receiver_holdoff();

    // anything still queued here was never produced
    if (expected_px.size() != 0) begin
      fail_count += expected_px.size();
      $display("%0d expected outputs never arrived", expected_px.size());
    end
    $display("Sent %0d samples in %0d lines, checked %0d interpolated outputs",
             items_sent, lines_sent, px_checked);
    $display("Covered short flushes, clipping, four idle mixes and a receiver hold-off");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
